### src/kcc_pkg.sv
// Shared constants, codes and control types of the k-clique counter.
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned CFG_W        = 5;
  localparam int unsigned CNT_W        = 14;
  localparam int unsigned PC_W         = $clog2(MAX_VERTICES + 1);

  localparam logic [CNT_W-1:0] CNT_MAX   = 14'd16383;
  localparam logic [CNT_W-1:0] CNT_BOUND = 14'd12870;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 5'd16;
  localparam logic [CFG_W-1:0] CLIQUE_SIZE_RST  = 5'd4;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_CLIQUE_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic add_edge;
    logic clear;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic done;
  } status_t;

endpackage

`default_nettype wire

### src/k_clique_counter_unit.sv
// Top level of the k-clique counter: controller and datapath.
// Edge and clear requests are taken one per cycle while the controller is idle.
// A count request starts the walk, then steps the depth-first walk (skipped when
// the count is trivial), then loads the result register once the output is free.
// The walk length is set by the number of partial cliques the candidate stack visits.
// Reset clears the adjacency matrix and sets vertex_count to 16 and clique_size to 4.
`timescale 1ns / 1ps
`default_nettype none

module k_clique_counter_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [kcc_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [kcc_pkg::VIDX_W-1:0] vertex_a_i,
  input  logic [kcc_pkg::VIDX_W-1:0] vertex_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [kcc_pkg::CNT_W-1:0]  clique_count_o
);
  import kcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  kcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kcc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .clique_count_o (clique_count_o)
  );

endmodule

`default_nettype wire

### src/kcc_ctrl.sv
// Controller state machine of the k-clique counter: request handshake and walk sequencing.
`timescale 1ns / 1ps
`default_nettype none

module kcc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      mode_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  kcc_pkg::status_t status_i,
  output kcc_pkg::cmd_t   cmd_o
);
  import kcc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode_i == MODE_COUNT)) begin
          state_d = status_i.trivial ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (status_i.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.add_edge = in_valid_i && (mode_i == MODE_EDGE);
        cmd_o.clear    = in_valid_i && (mode_i == MODE_CLEAR);
        cmd_o.start    = in_valid_i && (mode_i == MODE_COUNT);
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load_out = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### src/kcc_datapath.sv
// Datapath of the k-clique counter: adjacency matrix, candidate stack, counter and result.
`timescale 1ns / 1ps
`default_nettype none

module kcc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [kcc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [kcc_pkg::VIDX_W-1:0]  vertex_a_i,
  input  logic [kcc_pkg::VIDX_W-1:0]  vertex_b_i,
  input  kcc_pkg::cmd_t               cmd_i,
  output kcc_pkg::status_t            status_o,
  output logic [kcc_pkg::CNT_W-1:0]   clique_count_o
);
  import kcc_pkg::*;

  typedef logic [MAX_VERTICES-1:0] row_t;

  logic [CFG_W-1:0]  vcount_q, ksize_q;
  row_t              adj_q [MAX_VERTICES];
  row_t              adj_d [MAX_VERTICES];
  row_t              cand_q [MAX_VERTICES];
  logic [VIDX_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  res_q;

  logic [CFG_W-1:0]  n_eff;
  row_t              all_mask;
  logic              edge_ok;
  row_t              cur;
  logic [PC_W-1:0]   pc;
  logic [CFG_W-1:0]  need;
  logic              prune, last, pop;
  logic [VIDX_W-1:0] v;
  row_t              v_bit;
  logic [CNT_W:0]    sum;

  function automatic logic [PC_W-1:0] bits_set(input row_t x);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      c = c + PC_W'(x[i]);
    end
    return c;
  endfunction

  function automatic logic [VIDX_W-1:0] lowest_bit(input row_t x);
    logic [VIDX_W-1:0] r;
    r = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) begin
        r = VIDX_W'(i);
      end
    end
    return r;
  endfunction

  assign n_eff    = (vcount_q > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_q;
  assign all_mask = MAX_VERTICES'(({{MAX_VERTICES{1'b0}}, 1'b1} << n_eff) - 1'b1);
  assign edge_ok  = ({1'b0, vertex_a_i} < n_eff) && ({1'b0, vertex_b_i} < n_eff) &&
                    (vertex_a_i != vertex_b_i);

  assign cur   = cand_q[depth_q];
  assign pc    = bits_set(cur);
  assign need  = ksize_q - {1'b0, depth_q};
  assign prune = CFG_W'(pc) < need;
  assign last  = need == CFG_W'(1);
  assign pop   = prune || last;
  assign v     = lowest_bit(cur);
  assign v_bit = row_t'(1) << v;
  assign sum   = {1'b0, count_q} + (CNT_W + 1)'(pc);

  assign status_o.trivial = (ksize_q == '0) || (ksize_q > n_eff);
  assign status_o.done    = pop && (depth_q == '0);

  always_comb begin
    adj_d = adj_q;
    if (cmd_i.clear) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_d[r] = '0;
      end
    end else if (cmd_i.add_edge && edge_ok) begin
      adj_d[vertex_a_i][vertex_b_i] = 1'b1;
      adj_d[vertex_b_i][vertex_a_i] = 1'b1;
    end
  end

  always_comb begin
    depth_d = depth_q;
    count_d = count_q;
    if (cmd_i.start) begin
      depth_d = '0;
      count_d = (ksize_q == '0) ? CNT_W'(1) : '0;
    end else if (cmd_i.step) begin
      if (pop) begin
        if (!prune) begin
          count_d = (sum >= {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
        end
        if (depth_q != '0) begin
          depth_d = depth_q - 1'b1;
        end
      end else begin
        depth_d = depth_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VERTEX_COUNT_RST;
      ksize_q  <= CLIQUE_SIZE_RST;
      depth_q  <= '0;
      count_q  <= '0;
      for (int r = 0; r < MAX_VERTICES; r++) begin
        adj_q[r] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_VERTEX_COUNT: vcount_q <= cfg_wdata_i;
          CFG_CLIQUE_SIZE:  ksize_q  <= cfg_wdata_i;
          default:          vcount_q <= vcount_q;
        endcase
      end
      depth_q <= depth_d;
      count_q <= count_d;
      adj_q   <= adj_d;
    end
  end

  // The candidate stack is always written before it is read in a walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cand_q[0] <= all_mask;
    end else if (cmd_i.step && !pop) begin
      cand_q[depth_q]        <= cur & ~v_bit;
      cand_q[depth_q + 1'b1] <= cur & ~v_bit & adj_q[v];
    end
    if (cmd_i.load_out) begin
      res_q <= count_q;
    end
  end

  assign clique_count_o = res_q;

endmodule

`default_nettype wire

### src/kcc_checker.sv
// Port-level assertions of the k-clique counter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kcc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic [kcc_pkg::CNT_W-1:0]  clique_count_o
);
  import kcc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(clique_count_o))
    else $error("Result payload changed while stalled.");

  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_COUNT) |=> in_stall_o)
    else $error("Count request did not occupy the block.");

  a_other_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i != MODE_COUNT) |=> !in_stall_o)
    else $error("Edge or clear request stalled the next request.");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clique_count_o <= CNT_BOUND))
    else $error("Clique count exceeds the largest possible value.");

endmodule

bind k_clique_counter_unit kcc_checker u_kcc_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for k_clique_counter_unit with a clique-count predictor.
`timescale 1ns / 1ps

module tb_top;
  import kcc_pkg::*;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned ITEM_TARGET = 950;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned HOLD_AT     = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef enum logic {
    ROW_REG,
    ROW_REQ
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [1:0]         mode;
    logic [VIDX_W-1:0]  va;
    logic [VIDX_W-1:0]  vb;
    logic               ridx;
    logic [CFG_W-1:0]   rval;
    logic               fixed;
    logic [CNT_W-1:0]   count;
  } plan_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_idx_i   = CFG_VERTEX_COUNT;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i      = MODE_EDGE;
  logic [VIDX_W-1:0]  vertex_a_i  = '0;
  logic [VIDX_W-1:0]  vertex_b_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CNT_W-1:0]   clique_count_o;

  logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
  logic [CFG_W-1:0]        vc_reg = VERTEX_COUNT_RST;
  logic [CFG_W-1:0]        ks_reg = CLIQUE_SIZE_RST;
  logic [CNT_W-1:0]        counts_due [$];
  plan_row_t               plan [$];
  logic [CFG_W-1:0]        kv_list [4] = '{5'd8, 5'd16, 5'd15, 5'd1};
  int unsigned             errors        = 0;
  int unsigned             results_taken = 0;
  int unsigned             items_done    = 0;
  int unsigned             reg_writes    = 0;
  bit                      idle_free     = 1'b0;

  k_clique_counter_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .clique_count_o (clique_count_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(64'd3_000_000_000);
    $display("k_clique_counter_unit regression: fail");
    $finish;
  end

  function automatic int unsigned live_vertices();
    return (vc_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vc_reg);
  endfunction

  // Depth-first walk over candidate masks; each level keeps only later neighbors.
  function automatic logic [CNT_W-1:0] clique_total();
    logic [MAX_VERTICES-1:0] cand [MAX_VERTICES+1];
    int                      pos [MAX_VERTICES+1];
    logic [MAX_VERTICES-1:0] nxt;
    logic [31:0]             full;
    int                      n;
    int                      k;
    int                      depth;
    int                      v;
    int unsigned             total;
    n = int'(live_vertices());
    k = int'(ks_reg);
    if (k > n) return '0;
    if (k == 0) return CNT_W'(1);
    full = (32'd1 << n) - 32'd1;
    cand[0] = full[MAX_VERTICES-1:0];
    pos[0] = 0;
    depth = 0;
    total = 0;
    while (depth >= 0 && total < CNT_MAX) begin
      if (pos[depth] >= MAX_VERTICES) begin
        depth--;
      end else begin
        v = pos[depth];
        pos[depth]++;
        if (cand[depth][v]) begin
          nxt = cand[depth] & adj_rows[v] & ({MAX_VERTICES{1'b1}} << (v + 1));
          if (depth + 1 == k) begin
            total++;
          end else if ($countones(nxt) >= k - depth - 1) begin
            depth++;
            cand[depth] = nxt;
            pos[depth] = v + 1;
          end
        end
      end
    end
    return (total > CNT_MAX) ? CNT_MAX : total[CNT_W-1:0];
  endfunction

  function automatic void predict_request(input logic [1:0] mode,
                                          input logic [VIDX_W-1:0] va,
                                          input logic [VIDX_W-1:0] vb,
                                          input logic fixed,
                                          input logic [CNT_W-1:0] fixed_count);
    int unsigned n;
    n = live_vertices();
    case (mode)
      MODE_EDGE: begin
        if (va < n && vb < n && va != vb) begin
          adj_rows[va][vb] = 1'b1;
          adj_rows[vb][va] = 1'b1;
        end
      end
      MODE_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
      end
      MODE_COUNT: begin
        counts_due.insert(counts_due.size(), fixed ? fixed_count : clique_total());
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void plan_req(input logic [1:0] mode, input logic [VIDX_W-1:0] va,
                                   input logic [VIDX_W-1:0] vb, input logic fixed,
                                   input logic [CNT_W-1:0] count);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.mode = mode;
    r.va = va;
    r.vb = vb;
    r.fixed = fixed;
    r.count = count;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void plan_reg(input logic ridx, input logic [CFG_W-1:0] rval);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.ridx = ridx;
    r.rval = rval;
    plan.insert(plan.size(), r);
  endfunction

  task automatic send_request(input logic [1:0] mode, input logic [VIDX_W-1:0] va,
                              input logic [VIDX_W-1:0] vb, input logic fixed,
                              input logic [CNT_W-1:0] fixed_count);
    int unsigned gap;
    gap = idle_free ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    vertex_a_i <= va;
    vertex_b_i <= vb;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(mode, va, vb, fixed, fixed_count);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (counts_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vc_reg = val;
    else ks_reg = val;
    reg_writes++;
    @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned       wait_cycles;
    bit                held;
    logic [CNT_W-1:0]  due;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && results_taken >= HOLD_AT) begin
        wait_cycles = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        wait_cycles = idle_free ? 0 : $urandom_range(0, 5);
      end
      if (wait_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_taken++;
      if (counts_due.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected clique count %0d with nothing pending", clique_count_o);
      end else begin
        due = counts_due.pop_front();
        if (clique_count_o !== due) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("clique count mismatch: expected %0d, got %0d", due, clique_count_o);
        end
      end
    end
  end

  initial begin : stimulus
    logic [VIDX_W-1:0] va;
    logic [VIDX_W-1:0] vb;
    logic [CFG_W-1:0]  nv;
    logic [CFG_W-1:0]  kv;
    int unsigned       ne;
    int unsigned       hi;
    int unsigned       sel;
    int unsigned       len;
    foreach (adj_rows[i]) adj_rows[i] = '0;

    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd0);
    plan_req(MODE_EDGE, 4'd0, 4'd15, 1'b0, '0);
    plan_req(MODE_EDGE, 4'd15, 4'd0, 1'b0, '0);
    plan_req(MODE_EDGE, 4'd15, 4'd15, 1'b0, '0);
    plan_reg(CFG_CLIQUE_SIZE, 5'd2);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd1);
    plan_reg(CFG_CLIQUE_SIZE, 5'd0);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd1);
    plan_reg(CFG_CLIQUE_SIZE, 5'd31);
    plan_req(MODE_COUNT, 4'd15, 4'd15, 1'b1, 14'd0);
    plan_reg(CFG_VERTEX_COUNT, 5'd0);
    plan_reg(CFG_CLIQUE_SIZE, 5'd1);
    plan_req(MODE_EDGE, 4'd0, 4'd1, 1'b0, '0);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd0);
    plan_reg(CFG_CLIQUE_SIZE, 5'd0);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd1);
    plan_reg(CFG_VERTEX_COUNT, 5'd31);
    plan_reg(CFG_CLIQUE_SIZE, 5'd2);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd1);
    plan_reg(CFG_VERTEX_COUNT, 5'd4);
    plan_req(MODE_EDGE, 4'd4, 4'd3, 1'b0, '0);
    plan_req(MODE_EDGE, 4'd1, 4'd2, 1'b0, '0);
    plan_req(MODE_EDGE, 4'd2, 4'd3, 1'b0, '0);
    plan_req(MODE_EDGE, 4'd3, 4'd1, 1'b0, '0);
    plan_reg(CFG_CLIQUE_SIZE, 5'd3);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b0, '0);
    plan_reg(CFG_CLIQUE_SIZE, 5'd2);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b0, '0);
    plan_reg(CFG_VERTEX_COUNT, 5'd16);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b0, '0);
    plan_req(MODE_UNUSED, 4'd15, 4'd15, 1'b0, '0);
    plan_req(MODE_CLEAR, 4'd0, 4'd0, 1'b0, '0);
    plan_req(MODE_COUNT, 4'd0, 4'd0, 1'b1, 14'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_reg(plan[i].ridx, plan[i].rval);
      end else begin
        send_request(plan[i].mode, plan[i].va, plan[i].vb, plan[i].fixed, plan[i].count);
        items_done++;
      end
    end

    // The complete graph on all vertices gives the largest possible count.
    for (int a = 0; a < MAX_VERTICES - 1; a++) begin
      for (int b = a + 1; b < MAX_VERTICES; b++) begin
        if ($urandom_range(0, 1)) send_request(MODE_EDGE, VIDX_W'(a), VIDX_W'(b), 1'b0, '0);
        else send_request(MODE_EDGE, VIDX_W'(b), VIDX_W'(a), 1'b0, '0);
        items_done++;
      end
    end
    foreach (kv_list[i]) begin
      settle();
      write_reg(CFG_CLIQUE_SIZE, kv_list[i]);
      send_request(MODE_COUNT, VIDX_W'($urandom), VIDX_W'($urandom), 1'b0, '0);
      items_done++;
    end

    while (items_done < ITEM_TARGET) begin
      settle();
      idle_free = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: nv = 5'd0;
        1: nv = 5'd1;
        2: nv = CFG_W'($urandom_range(17, 31));
        3: nv = 5'd16;
        default: nv = CFG_W'($urandom_range(2, 16));
      endcase
      ne = (nv > MAX_VERTICES) ? MAX_VERTICES : int'(nv);
      hi = (ne + 1 < 6) ? ne + 1 : ((ne > 12) ? 5 : 6);
      case ($urandom_range(0, 9))
        0: kv = CFG_W'($urandom_range(0, 31));
        1: kv = 5'd0;
        default: kv = CFG_W'($urandom_range(1, hi));
      endcase
      write_reg(CFG_VERTEX_COUNT, nv);
      write_reg(CFG_CLIQUE_SIZE, kv);
      if ($urandom_range(0, 1)) begin
        send_request(MODE_CLEAR, VIDX_W'($urandom), VIDX_W'($urandom), 1'b0, '0);
        items_done++;
      end
      len = $urandom_range(10, 40);
      repeat (len) begin
        sel = $urandom_range(0, 19);
        va = VIDX_W'($urandom);
        vb = VIDX_W'($urandom);
        if (sel <= 12) begin
          if (ne >= 2) begin
            va = VIDX_W'($urandom_range(0, ne - 1));
            vb = VIDX_W'($urandom_range(0, ne - 2));
            if (vb >= va) vb++;
          end
          send_request(MODE_EDGE, va, vb, 1'b0, '0);
          items_done++;
        end else if (sel <= 15 || sel == 19) begin
          send_request(MODE_COUNT, va, vb, 1'b0, '0);
          items_done++;
        end else if (sel == 16) begin
          send_request(MODE_EDGE, va, vb, 1'b0, '0);
          items_done++;
        end else if (sel == 17) begin
          send_request(MODE_UNUSED, va, vb, 1'b0, '0);
          items_done++;
        end else begin
          send_request(MODE_CLEAR, va, vb, 1'b0, '0);
          items_done++;
        end
      end
    end

    settle();
    $display("Covered %0d requests and %0d register writes; %0d clique counts checked.",
             items_done, reg_writes, results_taken);
    $display("Errors found: %0d.", errors);
    if (errors == 0) begin
      $display("k_clique_counter_unit regression: pass");
    end else begin
      $display("k_clique_counter_unit regression: fail");
    end
    $finish;
  end

endmodule
